// ----- src/srecord_line_loader_unit_macros.svh -----
// Assertion macros for the checker file.
`ifndef SRECORD_LINE_LOADER_UNIT_MACROS_SVH
`define SRECORD_LINE_LOADER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define SRLL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define SRLL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/srll_pkg.sv -----
package srll_pkg;

    localparam logic       KIND_CHAR    = 1'b0;
    localparam logic       KIND_EOL     = 1'b1;
    localparam logic       RK_WRITE     = 1'b0;
    localparam logic       RK_SUMMARY   = 1'b1;
    localparam logic [3:0] TYPE_DATA16  = 4'd1;
    localparam logic [3:0] TYPE_UNKNOWN = 4'd10;
    localparam logic [9:0] POS_MAX      = 10'd1023;
    localparam logic [7:0] CHAR_S       = 8'h53;
    localparam logic [7:0] CHAR_0       = 8'h30;
    localparam logic [7:0] CHAR_9       = 8'h39;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } t_item;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
        logic [3:0]  record_type;
        logic [7:0]  record_count;
        logic [7:0]  record_checksum;
    } t_result;

    // Hex digit value; anything that is not a hex digit reads as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

endpackage

// ----- src/srll_in_if.sv -----
interface srll_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink   (input valid, input kind, input char_code, output ready);
endinterface

// ----- src/srll_out_if.sv -----
interface srll_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
    logic [3:0]  record_type;
    logic [7:0]  record_count;
    logic [7:0]  record_checksum;

    modport source (
        output valid, output result_kind, output mem_address, output mem_data,
        output record_type, output record_count, output record_checksum,
        input ready
    );
    modport sink (
        input valid, input result_kind, input mem_address, input mem_data,
        input record_type, input record_count, input record_checksum,
        output ready
    );
endinterface

// ----- src/srll_in_stage.sv -----
module srll_in_stage
    import srll_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_take,
    output logic  o_fire,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // The held item leaves when the parser can take it; a new one may land
    // in the same cycle.
    assign o_fire  = r_valid && i_take;
    assign o_ready = !r_valid || i_take;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- src/srll_parser.sv -----
module srll_parser
    import srll_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output logic    o_take,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic [9:0]  r_pos,        n_pos;
    logic        r_first_s,    n_first_s;
    logic [3:0]  r_type,       n_type;
    logic [7:0]  r_count,      n_count;
    logic [15:0] r_start,      n_start;
    logic [15:0] r_next_addr,  n_next_addr;
    logic [3:0]  r_pend,       n_pend;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_check,      n_check;
    logic        r_out_valid,  n_out_valid;
    t_result     r_res,        n_res;

    logic [3:0]  nib;
    logic [7:0]  pair;

    assign o_take   = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_res;
    assign nib      = hex_value(i_item.char_code);
    assign pair     = {r_pend, nib};

    always_comb begin
        n_pos        = r_pos;
        n_first_s    = r_first_s;
        n_type       = r_type;
        n_count      = r_count;
        n_start      = r_start;
        n_next_addr  = r_next_addr;
        n_pend       = r_pend;
        n_bytes_left = r_bytes_left;
        n_check      = r_check;
        n_out_valid  = r_out_valid && !i_ready;
        n_res        = r_res;

        if (i_fire) begin
            n_out_valid = 1'b0;
            if (i_item.kind == KIND_EOL) begin
                // A line with no characters gives no summary.
                if (r_pos != 10'd0) begin
                    n_out_valid           = 1'b1;
                    n_res.result_kind     = RK_SUMMARY;
                    n_res.mem_address     = r_start;
                    n_res.mem_data        = 8'h00;
                    n_res.record_type     = r_type;
                    n_res.record_count    = r_count;
                    n_res.record_checksum = r_check;
                end
                n_pos        = 10'd0;
                n_first_s    = 1'b0;
                n_type       = TYPE_UNKNOWN;
                n_count      = 8'h00;
                n_start      = 16'h0000;
                n_next_addr  = 16'h0000;
                n_pend       = 4'h0;
                n_bytes_left = 8'h00;
                n_check      = 8'h00;
            end else begin
                if (r_pos == 10'd0) begin
                    n_first_s = (i_item.char_code == CHAR_S);
                end else if (r_pos == 10'd1) begin
                    n_type = (r_first_s && i_item.char_code >= CHAR_0 &&
                              i_item.char_code <= CHAR_9) ?
                             i_item.char_code[3:0] : TYPE_UNKNOWN;
                end else if (r_pos == 10'd2) begin
                    n_pend = nib;
                end else if (r_pos == 10'd3) begin
                    n_count = pair;
                    // Data bytes plus the checksum byte.
                    n_bytes_left = (pair >= 8'd3) ? pair - 8'd2 : 8'd1;
                end else if (r_pos <= 10'd7) begin
                    n_start = {r_start[11:0], nib};
                    if (r_pos == 10'd7) begin
                        n_next_addr = {r_start[11:0], nib};
                    end
                end else if (!r_pos[0]) begin
                    n_pend = nib;
                end else if (r_bytes_left > 8'd1) begin
                    if (r_type == TYPE_DATA16) begin
                        n_out_valid           = 1'b1;
                        n_res.result_kind     = RK_WRITE;
                        n_res.mem_address     = r_next_addr;
                        n_res.mem_data        = pair;
                        n_res.record_type     = r_type;
                        n_res.record_count    = r_count;
                        n_res.record_checksum = 8'h00;
                    end
                    n_next_addr  = r_next_addr + 16'd1;
                    n_bytes_left = r_bytes_left - 8'd1;
                end else if (r_bytes_left == 8'd1) begin
                    n_check      = pair;
                    n_bytes_left = 8'd0;
                end
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= 10'd0;
            r_first_s    <= 1'b0;
            r_type       <= TYPE_UNKNOWN;
            r_count      <= 8'h00;
            r_start      <= 16'h0000;
            r_next_addr  <= 16'h0000;
            r_pend       <= 4'h0;
            r_bytes_left <= 8'h00;
            r_check      <= 8'h00;
            r_out_valid  <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_first_s    <= n_first_s;
            r_type       <= n_type;
            r_count      <= n_count;
            r_start      <= n_start;
            r_next_addr  <= n_next_addr;
            r_pend       <= n_pend;
            r_bytes_left <= n_bytes_left;
            r_check      <= n_check;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

// ----- src/srecord_line_loader_unit.sv -----
// Channel    Direction  Payload
// i_item     in         kind, char_code
// o_result   out        result_kind, mem_address, mem_data, record_type,
//                       record_count, record_checksum
//
// One item is taken per cycle while the result side is not stalled; each item is
// registered in the input stage and its result in the parser's result register.
// Reset is synchronous and active low, and clears the line state and both stages.
// A stalled result holds the parser, the input register then fills, and
// i_item.ready drops until the result is taken.
module srecord_line_loader_unit
    import srll_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    srll_in_if.sink     i_item,
    srll_out_if.source  o_result
);

    t_item   in_item;
    t_item   stage_item;
    t_result res;
    logic    take;
    logic    fire;

    assign in_item.kind      = i_item.kind;
    assign in_item.char_code = i_item.char_code;

    srll_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_item  (in_item),
        .o_ready (i_item.ready),
        .i_take  (take),
        .o_fire  (fire),
        .o_item  (stage_item)
    );

    srll_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .o_take   (take),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_result (res)
    );

    assign o_result.result_kind     = res.result_kind;
    assign o_result.mem_address     = res.mem_address;
    assign o_result.mem_data        = res.mem_data;
    assign o_result.record_type     = res.record_type;
    assign o_result.record_count    = res.record_count;
    assign o_result.record_checksum = res.record_checksum;

endmodule

// ----- src/srll_checker.sv -----
`include "srecord_line_loader_unit_macros.svh"

module srll_checker
    import srll_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_result_kind,
    input logic [15:0] i_mem_address,
    input logic [7:0]  i_mem_data,
    input logic [3:0]  i_record_type,
    input logic [7:0]  i_record_checksum
);

    `SRLL_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_mem_address) && $stable(i_mem_data) && $stable(i_result_kind), "result changed while stalled")
    `SRLL_ASSERT_NOW(a_summary_data, i_out_valid && i_result_kind == RK_SUMMARY, i_mem_data == 8'h00, "summary carries a data byte")
    `SRLL_ASSERT_NOW(a_write_type, i_out_valid && i_result_kind == RK_WRITE, i_record_type == TYPE_DATA16 && i_record_checksum == 8'h00, "write from a record that is not S1")
    `SRLL_ASSERT_NOW(a_type_range, i_out_valid, i_record_type <= TYPE_UNKNOWN, "record type out of range")

endmodule

bind srecord_line_loader_unit srll_checker u_srll_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_result_kind     (o_result.result_kind),
    .i_mem_address     (o_result.mem_address),
    .i_mem_data        (o_result.mem_data),
    .i_record_type     (o_result.record_type),
    .i_record_checksum (o_result.record_checksum)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

import srll_pkg::*;

localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
localparam logic [7:0] CHAR_UPPER_F  = 8'h46;
localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
localparam logic [7:0] CHAR_LOWER_F  = 8'h66;
localparam logic [7:0] COUNT_OVERHEAD = 8'd3;

// Tracks the line being parsed and queues the writes and summaries it must produce.
class srecord_tracker;
    logic [9:0]  char_pos;
    logic        lead_is_s;
    logic [3:0]  rec_type;
    logic [7:0]  byte_count;
    logic [15:0] load_addr;
    logic [15:0] write_addr;
    logic [3:0]  high_nibble;
    logic [7:0]  bytes_to_read;
    logic [7:0]  checksum_seen;
    t_result     awaited[$];
    int unsigned error_count;

    function new();
        error_count = 0;
        clear_line();
    endfunction

    function void clear_line();
        char_pos      = '0;
        lead_is_s     = 1'b0;
        rec_type      = TYPE_UNKNOWN;
        byte_count    = '0;
        load_addr     = '0;
        write_addr    = '0;
        high_nibble   = '0;
        bytes_to_read = '0;
        checksum_seen = '0;
    endfunction

    function logic [3:0] nibble_of(logic [7:0] c);
        if (c >= CHAR_0 && c <= CHAR_9) begin
            return 4'(c - CHAR_0);
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            return 4'(c - CHAR_UPPER_A + 8'd10);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            return 4'(c - CHAR_LOWER_A + 8'd10);
        end
        return 4'd0;
    endfunction

    function t_result make_result(logic rk, logic [15:0] addr, logic [7:0] data,
                                  logic [7:0] chk);
        t_result r;
        r.result_kind     = rk;
        r.mem_address     = addr;
        r.mem_data        = data;
        r.record_type     = rec_type;
        r.record_count    = byte_count;
        r.record_checksum = chk;
        return r;
    endfunction

    function void note_item(t_item it);
        logic [3:0] nib;
        logic [7:0] value;
        if (it.kind == KIND_EOL) begin
            // A line with no characters at all produces no summary.
            if (char_pos != 0) begin
                awaited.push_back(make_result(RK_SUMMARY, load_addr, 8'd0, checksum_seen));
            end
            clear_line();
            return;
        end
        nib = nibble_of(it.char_code);
        if (char_pos == 0) begin
            lead_is_s = (it.char_code == CHAR_S);
        end else if (char_pos == 1) begin
            rec_type = (lead_is_s && it.char_code >= CHAR_0 && it.char_code <= CHAR_9) ?
                       4'(it.char_code - CHAR_0) : TYPE_UNKNOWN;
        end else if (char_pos == 2) begin
            high_nibble = nib;
        end else if (char_pos == 3) begin
            byte_count    = {high_nibble, nib};
            bytes_to_read = (byte_count >= COUNT_OVERHEAD) ? byte_count - 8'd2 : 8'd1;
        end else if (char_pos <= 7) begin
            load_addr = {load_addr[11:0], nib};
            if (char_pos == 7) begin
                write_addr = load_addr;
            end
        end else if (!char_pos[0]) begin
            high_nibble = nib;
        end else begin
            value = {high_nibble, nib};
            if (bytes_to_read > 1) begin
                if (rec_type == TYPE_DATA16) begin
                    awaited.push_back(make_result(RK_WRITE, write_addr, value, 8'd0));
                end
                write_addr    = write_addr + 16'd1;
                bytes_to_read = bytes_to_read - 8'd1;
            end else if (bytes_to_read == 1) begin
                checksum_seen = value;
                bytes_to_read = 8'd0;
            end
        end
        if (char_pos < POS_MAX) begin
            char_pos = char_pos + 10'd1;
        end
    endfunction

    function void mismatch(string field, logic [15:0] want, logic [15:0] got);
        error_count++;
        if (error_count <= 40) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
        end
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (awaited.size() == 0) begin
            error_count++;
            if (error_count <= 40) begin
                $display("%0t: result expected none, got %h", $time, got);
            end
            return;
        end
        want = awaited.pop_front();
        if (got.result_kind !== want.result_kind) begin
            mismatch("result_kind", want.result_kind, got.result_kind);
        end
        if (got.mem_address !== want.mem_address) begin
            mismatch("mem_address", want.mem_address, got.mem_address);
        end
        if (got.mem_data !== want.mem_data) begin
            mismatch("mem_data", want.mem_data, got.mem_data);
        end
        if (got.record_type !== want.record_type) begin
            mismatch("record_type", want.record_type, got.record_type);
        end
        if (got.record_count !== want.record_count) begin
            mismatch("record_count", want.record_count, got.record_count);
        end
        if (got.record_checksum !== want.record_checksum) begin
            mismatch("record_checksum", want.record_checksum, got.record_checksum);
        end
    endfunction

    function int unsigned outstanding();
        return awaited.size();
    endfunction
endclass

module tb;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 1950;
    localparam int unsigned LONG_LINE    = 1030;

    logic i_clk;
    logic i_rst_n;

    srll_in_if  item_bus();
    srll_out_if result_bus();

    srecord_line_loader_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    srecord_tracker tracker = new();
    logic [7:0]     line_chars[$];
    int unsigned    items_sent;
    int unsigned    cycle_count;
    bit             sender_eager;
    bit             receiver_eager;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) begin
            return CHAR_0 + 8'(n);
        end
        return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(n - 4'd10);
    endfunction

    function automatic void add_hex(logic [15:0] v, int digits);
        for (int i = digits - 1; i >= 0; i--) begin
            line_chars.push_back(hex_char(v[i*4 +: 4]));
        end
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            line_chars.push_back(s[i]);
        end
    endfunction

    // Leaves valid untouched after the transfer so that a back-to-back item
    // never lowers and raises it within the same step.
    task automatic send_item(input logic k, input logic [7:0] ch);
        int unsigned gap;
        t_item       it;
        gap = sender_eager ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.kind      <= k;
        item_bus.char_code <= ch;
        do @(negedge i_clk); while (!item_bus.ready);
        it.kind      = k;
        it.char_code = ch;
        tracker.note_item(it);
        items_sent++;
        @(posedge i_clk);
    endtask

    task automatic send_line();
        sender_eager = ($urandom_range(0, 3) == 0);
        foreach (line_chars[i]) begin
            send_item(KIND_CHAR, line_chars[i]);
        end
        send_item(KIND_EOL, 8'($urandom_range(0, 255)));
        line_chars.delete();
    endtask

    task automatic hold_until_drained();
        item_bus.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
    endtask

    task automatic build_random_line();
        int unsigned shape;
        int unsigned pick;
        int unsigned count;
        int unsigned cut;
        shape = $urandom_range(0, 99);
        if (shape < 8) begin
            // Plain noise, including the odd empty line.
            repeat ($urandom_range(0, 20)) line_chars.push_back(8'($urandom_range(0, 255)));
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            add_text("S1");
        end else if (pick < 85) begin
            line_chars.push_back(CHAR_S);
            line_chars.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
        end else if (pick < 92) begin
            line_chars.push_back(CHAR_S);
            line_chars.push_back(8'($urandom_range(0, 255)));
        end else begin
            line_chars.push_back(8'($urandom_range(0, 255)));
            line_chars.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            count = $urandom_range(0, 12);
        end else if (pick < 98) begin
            count = $urandom_range(13, 40);
        end else begin
            count = $urandom_range(41, 255);
        end
        add_hex(16'(count), 2);
        add_hex(16'($urandom_range(0, 65535)), 4);
        if (count > COUNT_OVERHEAD) begin
            repeat (count - COUNT_OVERHEAD) add_hex(16'($urandom_range(0, 255)), 2);
        end
        add_hex(16'($urandom_range(0, 255)), 2);
        if ($urandom_range(0, 9) == 0) begin
            line_chars[$urandom_range(2, line_chars.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, line_chars.size());
            while (line_chars.size() > cut) void'(line_chars.pop_back());
        end
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 5)) line_chars.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Full-length S1 record, then padding past the point where the position
    // counter saturates.
    task automatic build_long_line();
        add_text("S1FF");
        add_hex(16'($urandom_range(0, 65535)), 4);
        repeat (252) add_hex(16'($urandom_range(0, 255)), 2);
        add_hex(16'($urandom_range(0, 255)), 2);
        while (line_chars.size() < LONG_LINE) begin
            line_chars.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        t_result got;
        int unsigned gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 23) == 0) begin
                receiver_eager = !receiver_eager;
            end
            gap = receiver_eager ? 0 : $urandom_range(0, 16);
            if (gap != 0) begin
                result_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
            do @(negedge i_clk); while (!result_bus.valid);
            got.result_kind     = result_bus.result_kind;
            got.mem_address     = result_bus.mem_address;
            got.mem_data        = result_bus.mem_data;
            got.record_type     = result_bus.record_type;
            got.record_count    = result_bus.record_count;
            got.record_checksum = result_bus.record_checksum;
            @(posedge i_clk);
            tracker.check_result(got);
        end
    end

    initial begin
        cycle_count        = 0;
        items_sent         = 0;
        sender_eager       = 1'b0;
        receiver_eager     = 1'b0;
        i_rst_n            <= 1'b0;
        item_bus.valid     <= 1'b0;
        item_bus.kind      <= KIND_CHAR;
        item_bus.char_code <= 8'd0;
        result_bus.ready   <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // An empty line, a wrapping S1 record in mixed case, a short count
        // with a non-hex address digit and trailing junk, and a truncated line.
        send_line();
        add_text("S105FFFFa1B2cc");
        send_line();
        add_text("S902g0E1Ff!");
        send_line();
        add_text("T");
        send_line();
        hold_until_drained();

        // Room is left for the long line so that the total stays near the target.
        while (items_sent + LONG_LINE < RANDOM_ITEMS) begin
            build_random_line();
            send_line();
        end
        hold_until_drained();
        build_long_line();
        send_line();

        item_bus.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
        repeat (8) @(posedge i_clk);
        if (tracker.error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
